// ===== rtl/least_loaded_interrupt_steering_unit_assert.svh =====
// Assertion macros shared by the checker of the steering unit.
`ifndef LEAST_LOADED_INTERRUPT_STEERING_UNIT_ASSERT_SVH
`define LEAST_LOADED_INTERRUPT_STEERING_UNIT_ASSERT_SVH

// Check a condition in every cycle out of reset.
`define LIS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define LIS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/lis_pkg.sv =====
package lis_pkg;

  localparam int NUM_CPUS_DEF  = 32;
  localparam int NUM_BUSES_DEF = 16;

  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int BOOT_W     = 5;
  localparam int PRES_W     = 32;
  localparam int BUSP_W     = 16;
  localparam int OP_W       = 2;
  localparam int CPU_W      = 5;
  localparam int BUS_IDX_W  = 4;
  localparam int TGT_ID_W   = 8;
  localparam int TGT_SHIFT  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_DISTRIBUTE = 2'd0,
    OP_DISABLE    = 2'd1,
    OP_ENABLE     = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOOT_CPU       = 2'd0,
    REG_CPU_PRESENT    = 2'd1,
    REG_BOOTBUS_OWNERS = 2'd2,
    REG_BUS_PRESENT    = 2'd3
  } reg_e;

  typedef struct packed {
    logic clear;
    logic sample;
    logic elig;
  } pick_ctl_t;

  typedef struct packed {
    logic                 kind;
    logic [BUS_IDX_W-1:0] bus_index;
    logic [CPU_W-1:0]     target_cpu;
    logic [TGT_ID_W-1:0]  target_id;
    logic                 busy_res;
    logic                 no_target;
    logic [CPU_W-1:0]     last_active;
    logic                 last;
  } res_item_t;

endpackage

// ===== rtl/lis_load_ram.sv =====
module lis_load_ram #(
  parameter int DEPTH = lis_pkg::NUM_CPUS_DEF,
  parameter int DW    = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_all_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0]    rdata_q;
  logic             rvld_q;

  // valid bits: an entry never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (clr_all_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/lis_pick_unit.sv =====
module lis_pick_unit #(
  parameter int CW    = 5,
  parameter int CNTW  = 5,
  parameter int NBUS  = lis_pkg::NUM_BUSES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lis_pkg::pick_ctl_t ctl_i,
  input  logic [CW-1:0]     idx_i,
  input  logic [CNTW-1:0]   ent_cnt_i,
  input  logic [NBUS-1:0]   ent_mask_i,
  output logic              found_o,
  output logic [CW-1:0]     best_idx_o,
  output logic [CNTW-1:0]   best_cnt_o,
  output logic [NBUS-1:0]   best_mask_o
);

  logic            smp_q;
  logic            elig_q;
  logic            found_q;
  logic [CW-1:0]   idx_q;
  logic [CW-1:0]   best_idx_q;
  logic [CNTW-1:0] best_cnt_q;
  logic [NBUS-1:0] best_mask_q;
  logic            take;

  // strictly smaller count wins, so the first candidate in scan order keeps ties
  assign take = smp_q && elig_q && (!found_q || (ent_cnt_i < best_cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q   <= 1'b0;
      elig_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      smp_q   <= 1'b0;
      elig_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      smp_q  <= ctl_i.sample;
      elig_q <= ctl_i.elig;
      if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_i;
    if (take) begin
      best_idx_q  <= idx_q;
      best_cnt_q  <= ent_cnt_i;
      best_mask_q <= ent_mask_i;
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_cnt_o  = best_cnt_q;
  assign best_mask_o = best_mask_q;

endmodule

// ===== rtl/lis_out_reg.sv =====
module lis_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lis_pkg::res_item_t item_i,
  input  logic               ready_i,
  output logic               valid_o,
  output lis_pkg::res_item_t item_o,
  output logic               free_o
);

  logic               valid_q;
  lis_pkg::res_item_t item_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/least_loaded_interrupt_steering_unit.sv =====
// Sequence: an ignored operation (unused code or processor out of range) goes straight to
// its status transfer. Distribute and enable walk all NUM_BUSES bus slots; each bus to
// assign scans the load table (one load-table entry per cycle), then takes a compare stage
// and a write-back, and the status item closes the operation; disable, when it drops the
// highest active, first walks down for the next lower one, then reads the owned mask.
// Throughput: one operation at a time; a waiting result holds the
// sequencer. Reset is asynchronous, active low: registers take their reset values and the
// load table reads as zero through cleared valid bits, no sweep.
module least_loaded_interrupt_steering_unit #(
  parameter int NUM_CPUS  = lis_pkg::NUM_CPUS_DEF,
  parameter int NUM_BUSES = lis_pkg::NUM_BUSES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lis_pkg::CFG_W-1:0]     cfg_wdata_i,
  // operation channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lis_pkg::OP_W-1:0]      operation_i,
  input  logic [lis_pkg::CPU_W-1:0]     proc_idx_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [lis_pkg::BUS_IDX_W-1:0] bus_index_o,
  output logic [lis_pkg::CPU_W-1:0]     target_cpu_o,
  output logic [lis_pkg::TGT_ID_W-1:0]  target_id_o,
  output logic                          busy_res_o,
  output logic                          no_target_o,
  output logic [lis_pkg::CPU_W-1:0]     last_active_o,
  output logic                          last_o
);

  localparam int CW   = $clog2(NUM_CPUS);
  localparam int BW   = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
  localparam int CNTW = $clog2(NUM_BUSES + 1);
  localparam int DW   = CNTW + NUM_BUSES;
  localparam int HW   = ((CW > lis_pkg::BOOT_W) ? CW : lis_pkg::BOOT_W) + 1;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_HIGH     = 9'b000000010,
    S_OWN_RD   = 9'b000000100,
    S_OWN_WT   = 9'b000001000,
    S_BUS      = 9'b000010000,
    S_SCAN     = 9'b000100000,
    S_SCAN_END = 9'b001000000,
    S_ASSIGN   = 9'b010000000,
    S_STATUS   = 9'b100000000
  } state_e;

  // a scan that would start past the last processor starts at processor 0
  function automatic logic [CW-1:0] norm_hint(input logic [HW-1:0] raw);
    logic [CW-1:0] res;
    if (raw >= HW'(NUM_CPUS)) begin
      res = '0;
    end else begin
      res = CW'(raw);
    end
    return res;
  endfunction

  state_e state_q, state_d;

  // configuration registers
  logic [lis_pkg::BOOT_W-1:0] boot_q;
  logic [lis_pkg::PRES_W-1:0] pres_q;
  logic [lis_pkg::PRES_W-1:0] own_q;
  logic [lis_pkg::BUSP_W-1:0] busp_q;

  // architectural state besides the load table
  logic [NUM_CPUS-1:0]       en_q, en_d;
  logic [lis_pkg::CPU_W-1:0] high_q, high_d;

  // per-operation working registers
  logic                 dis_q, dis_d;
  logic                 busy_q, busy_d;
  logic [CW-1:0]        cp_q, cp_d;
  logic [CW-1:0]        hscan_q, hscan_d;
  logic [NUM_BUSES-1:0] walk_q, walk_d;
  logic [BW-1:0]        bus_q, bus_d;
  logic [CW-1:0]        k_q, k_d;
  logic [CW-1:0]        hint_q, hint_d;

  logic [NUM_CPUS-1:0]  pres_ext;
  logic [NUM_CPUS-1:0]  elig_vec;
  logic [NUM_BUSES-1:0] bus_vec;
  logic [CW:0]          scan_sum;
  logic [CW-1:0]        scan_idx;
  logic [CW-1:0]        hscan_m1;
  logic [CW-1:0]        cp_idx;
  logic                 in_rng;
  logic                 bus_last;
  logic                 k_last;

  logic                 ram_clr;
  logic                 ram_we;
  logic [CW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [CW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [CNTW-1:0]      ram_cnt;
  logic [NUM_BUSES-1:0] ram_mask;

  lis_pkg::pick_ctl_t   pk_ctl;
  logic                 pk_found;
  logic [CW-1:0]        pk_idx;
  logic [CNTW-1:0]      pk_cnt;
  logic [NUM_BUSES-1:0] pk_mask;

  logic                 out_load;
  logic                 out_free;
  lis_pkg::res_item_t   out_item;
  lis_pkg::res_item_t   res_q;

  // processor slots beyond the present register never exist; likewise bus slots
  for (genvar j = 0; j < NUM_CPUS; j++) begin : g_pres
    if (j < lis_pkg::PRES_W) begin : g_in
      assign pres_ext[j] = pres_q[j];
    end else begin : g_out
      assign pres_ext[j] = 1'b0;
    end
  end

  for (genvar j = 0; j < NUM_BUSES; j++) begin : g_bus
    if (j < lis_pkg::BUSP_W) begin : g_in
      assign bus_vec[j] = busp_q[j];
    end else begin : g_out
      assign bus_vec[j] = 1'b0;
    end
  end

  assign elig_vec = pres_ext & en_q;

  // circular scan position: hint plus step, folded once
  assign scan_sum = {1'b0, hint_q} + {1'b0, k_q};
  assign scan_idx = (scan_sum >= (CW+1)'(NUM_CPUS)) ? CW'(scan_sum - (CW+1)'(NUM_CPUS))
                                                     : CW'(scan_sum);

  assign hscan_m1 = hscan_q - CW'(1);
  assign cp_idx   = CW'(proc_idx_i);
  assign in_rng   = (32'(proc_idx_i) < NUM_CPUS);
  assign bus_last = (bus_q == BW'(NUM_BUSES - 1));
  assign k_last   = (k_q == CW'(NUM_CPUS - 1));

  assign ram_cnt  = ram_rdata[DW-1 -: CNTW];
  assign ram_mask = ram_rdata[NUM_BUSES-1:0];

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    en_d      = en_q;
    high_d    = high_q;
    dis_d     = dis_q;
    busy_d    = busy_q;
    cp_d      = cp_q;
    hscan_d   = hscan_q;
    walk_d    = walk_q;
    bus_d     = bus_q;
    k_d       = k_q;
    hint_d    = hint_q;
    ram_clr   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cp_q;
    ram_wdata = '0;
    ram_raddr = scan_idx;
    pk_ctl    = '0;
    out_load  = 1'b0;
    out_item  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          busy_d  = 1'b0;
          dis_d   = 1'b0;
          bus_d   = '0;
          walk_d  = bus_vec;
          cp_d    = cp_idx;
          hscan_d = cp_idx;
          hint_d  = norm_hint(HW'(boot_q) + HW'(1));
          case (operation_i)
            lis_pkg::OP_DISTRIBUTE: begin
              state_d = S_BUS;
            end
            lis_pkg::OP_ENABLE: begin
              if (in_rng) begin
                // enable wipes the table and redistributes from scratch
                en_d[cp_idx] = 1'b1;
                ram_clr      = 1'b1;
                if (proc_idx_i > high_q) begin
                  high_d = proc_idx_i;
                end
                state_d = S_BUS;
              end else begin
                state_d = S_STATUS;
              end
            end
            lis_pkg::OP_DISABLE: begin
              if (in_rng) begin
                en_d[cp_idx] = 1'b0;
                dis_d        = 1'b1;
                busy_d       = (proc_idx_i == boot_q) || own_q[proc_idx_i];
                state_d      = (proc_idx_i == high_q) ? S_HIGH : S_OWN_RD;
              end else begin
                state_d = S_STATUS;
              end
            end
            default: begin
              state_d = S_STATUS;
            end
          endcase
        end
      end
      S_HIGH: begin
        // walk down for the next lower eligible processor; keep the old value if none
        if (hscan_q == '0) begin
          state_d = S_OWN_RD;
        end else begin
          hscan_d = hscan_m1;
          if (elig_vec[hscan_m1]) begin
            high_d  = lis_pkg::CPU_W'(hscan_m1);
            state_d = S_OWN_RD;
          end
        end
      end
      S_OWN_RD: begin
        ram_raddr = cp_q;
        state_d   = S_OWN_WT;
      end
      S_OWN_WT: begin
        // take the owned mask and clear the entry; the processor is no longer eligible
        walk_d  = ram_mask;
        ram_we  = 1'b1;
        hint_d  = norm_hint(HW'(cp_q) + HW'(1));
        bus_d   = '0;
        state_d = S_BUS;
      end
      S_BUS: begin
        if (walk_q[bus_q]) begin
          pk_ctl.clear = 1'b1;
          k_d          = '0;
          state_d      = S_SCAN;
        end else if (bus_last) begin
          state_d = S_STATUS;
        end else begin
          bus_d = bus_q + BW'(1);
        end
      end
      S_SCAN: begin
        pk_ctl.sample = 1'b1;
        pk_ctl.elig   = elig_vec[scan_idx];
        k_d           = k_q + CW'(1);
        if (k_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last entry still in the compare stage
        state_d = S_ASSIGN;
      end
      S_ASSIGN: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_item.kind        = 1'b0;
          out_item.bus_index   = lis_pkg::BUS_IDX_W'(bus_q);
          out_item.no_target   = !pk_found;
          out_item.last_active = high_q;
          if (pk_found) begin
            out_item.target_cpu = lis_pkg::CPU_W'(pk_idx);
            out_item.target_id  = lis_pkg::TGT_ID_W'(pk_idx) << lis_pkg::TGT_SHIFT;
            ram_we              = 1'b1;
            ram_waddr           = pk_idx;
            ram_wdata           = {pk_cnt + CNTW'(!pk_mask[bus_q]),
                                   pk_mask | (NUM_BUSES'(1) << bus_q)};
            // distribute and enable advance past each winner; disable rescans from the same hint
            if (!dis_q) begin
              hint_d = norm_hint(HW'(pk_idx) + HW'(1));
            end
          end
          if (bus_last) begin
            state_d = S_STATUS;
          end else begin
            bus_d   = bus_q + BW'(1);
            state_d = S_BUS;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_item.kind        = 1'b1;
          out_item.busy_res    = busy_q;
          out_item.last_active = high_q;
          out_item.last        = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration writes are taken in any state; write only while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q <= '0;
      pres_q <= lis_pkg::PRES_W'(1);
      own_q  <= '0;
      busp_q <= lis_pkg::BUSP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lis_pkg::REG_BOOT_CPU:       boot_q <= cfg_wdata_i[lis_pkg::BOOT_W-1:0];
        lis_pkg::REG_CPU_PRESENT:    pres_q <= cfg_wdata_i[lis_pkg::PRES_W-1:0];
        lis_pkg::REG_BOOTBUS_OWNERS: own_q  <= cfg_wdata_i[lis_pkg::PRES_W-1:0];
        lis_pkg::REG_BUS_PRESENT:    busp_q <= cfg_wdata_i[lis_pkg::BUSP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      en_q    <= NUM_CPUS'(1);
      high_q  <= '0;
      dis_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      en_q    <= en_d;
      high_q  <= high_d;
      dis_q   <= dis_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q    <= cp_d;
    hscan_q <= hscan_d;
    walk_q  <= walk_d;
    bus_q   <= bus_d;
    k_q     <= k_d;
    hint_q  <= hint_d;
  end

  lis_load_ram #(
    .DEPTH (NUM_CPUS),
    .DW    (DW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_all_i (ram_clr),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_i   (ram_raddr),
    .rdata_o   (ram_rdata)
  );

  lis_pick_unit #(
    .CW   (CW),
    .CNTW (CNTW),
    .NBUS (NUM_BUSES)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pk_ctl),
    .idx_i       (scan_idx),
    .ent_cnt_i   (ram_cnt),
    .ent_mask_i  (ram_mask),
    .found_o     (pk_found),
    .best_idx_o  (pk_idx),
    .best_cnt_o  (pk_cnt),
    .best_mask_o (pk_mask)
  );

  lis_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .item_i  (out_item),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .item_o  (res_q),
    .free_o  (out_free)
  );

  assign kind_o        = res_q.kind;
  assign bus_index_o   = res_q.bus_index;
  assign target_cpu_o  = res_q.target_cpu;
  assign target_id_o   = res_q.target_id;
  assign busy_res_o    = res_q.busy_res;
  assign no_target_o   = res_q.no_target;
  assign last_active_o = res_q.last_active;
  assign last_o        = res_q.last;

endmodule

// ===== rtl/lis_checker.sv =====
`include "least_loaded_interrupt_steering_unit_assert.svh"

module lis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          kind_o,
  input logic [lis_pkg::CPU_W-1:0]     target_cpu_o,
  input logic [lis_pkg::TGT_ID_W-1:0]  target_id_o,
  input logic                          no_target_o,
  input logic                          last_o
);

  logic no_cpu_item;

  assign no_cpu_item = out_valid_o && (kind_o || no_target_o);

  // an accepted operation always keeps the block busy in the next cycle
  `LIS_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && in_ready_o, !in_ready_o, "ready too soon")

  // a waiting result holds until its transfer
  `LIS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // only the closing status item carries last
  `LIS_ASSERT(a_last_is_status, !out_valid_o || (kind_o == last_o), "last and kind disagree")

  // target id follows the chosen processor
  `LIS_ASSERT(a_target_id, !out_valid_o || (target_id_o == {target_cpu_o, 3'b000}), "bad id")

  // skipped assignments and status items carry no processor
  `LIS_ASSERT(a_empty_target, !no_cpu_item || (target_cpu_o == '0), "target set")

endmodule

bind least_loaded_interrupt_steering_unit lis_checker u_lis_checker (.*);
